>>> design/md5sh_pkg.sv
// ============================================================================
// MD5 stream hash package
// Types, constants and functions shared by the MD5 stream hash block: beat
// payloads, initial chaining values, round constants and round scheduling.
// ============================================================================
package md5sh_pkg;

    // Input beat: one optional message byte and the end-of-message flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } md5sh_in_t;

    // Result beat: one digest word with its index.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md5sh_out_t;

    // Initial chaining words A, B, C and D.
    localparam logic [3:0][31:0] MD5_IV = {
        32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    // Padding marker byte and the first byte position of the length field.
    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_START  = 6'd56;

    // Per-round additive constant.
    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left rotation amount for a round.
    function automatic logic [4:0] rot_amount(input logic [5:0] idx);
        logic [4:0] s;
        unique case ({idx[5:4], idx[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used by a round; the multipliers wrap modulo sixteen.
    function automatic logic [3:0] msg_index(input logic [5:0] idx);
        logic [3:0] j;
        logic [3:0] m;
        j = idx[3:0];
        unique case (idx[5:4])
            2'd0: m = j;
            2'd1: m = (j << 2) + j + 4'd1;
            2'd2: m = (j << 1) + j + 4'd5;
            2'd3: m = (j << 3) - j;
            default: m = j;
        endcase
        return m;
    endfunction

    // Rotate a word left by a non-zero amount.
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

endpackage

>>> design/md5_stream_hash.sv
// ============================================================================
// MD5 stream hash
// Hashes a byte stream with MD5 and returns the four digest words per message.
// ============================================================================
//
// Input channel s_*: one beat carries an optional message byte and an
// end-of-message flag. A beat with neither is taken and has no effect.
// Result channel m_*: four beats per message, words A, B, C and D in order,
// each word holding digest bytes in little-endian order; last_word marks D.
// While bytes are being gathered one beat is taken every cycle. Each full
// 64-byte block then stalls the input while it is compressed: ST_CPRE primes
// the block store read, ST_CRND runs one round per cycle for 64 rounds, and
// ST_CFIN folds the result into the chaining words. A block store of sixteen
// words with a registered read supplies the message word for each round.
// Finishing a message takes a setup state, a write of each padded word up to
// the end of the block, and one compression (two when fewer than
// nine byte slots remain), after which the four digest words are presented.
// The input stays stalled until the receiver has taken all four words; a
// stalled receiver simply holds the current word. Reset (aresetn low,
// synchronous) loads the initial chaining words and clears the byte and bit
// counts; the block store needs no clearing since padding overwrites every
// word that a message did not write.
//
module md5_stream_hash
    import md5sh_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  md5sh_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output md5sh_out_t m_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_FIN  = 7'b0000010,
        ST_PAD  = 7'b0000100,
        ST_CPRE = 7'b0001000,
        ST_CRND = 7'b0010000,
        ST_CFIN = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [3:0][31:0] chain_reg, chain_next;
    logic [31:0]      a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [5:0]       round_reg, round_next;
    logic [5:0]       fill_reg, fill_next;
    logic [63:0]      bitlen_reg, bitlen_next;
    logic [31:0]      word_reg, word_next;
    logic [3:0]       pad_ptr_reg, pad_ptr_next;
    logic             pad_first_reg, pad_first_next;
    logic             len_pass_reg, len_pass_next;
    logic             pad_active_reg, pad_active_next;
    logic             finish_pending_reg, finish_pending_next;
    logic [1:0]       out_idx_reg, out_idx_next;

    // Block store and its port signals.
    logic [31:0]      blk_mem [16];
    logic [31:0]      mem_rdata_reg;
    logic             mem_we;
    logic [3:0]       mem_waddr;
    logic [31:0]      mem_wdata;
    logic [3:0]       rd_addr;

    logic             s_beat, m_beat;
    logic [31:0]      f_val, sum_val, b_new, pad_word;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign s_beat  = s_valid & s_ready;
    assign m_beat  = m_valid & m_ready;

    // Result beat payload comes straight from the held chaining words.
    always_comb begin
        m_data.digest_word = chain_reg[out_idx_reg];
        m_data.word_index  = out_idx_reg;
        m_data.last_word   = (out_idx_reg == 2'd3);
    end

    // Round function for the current round.
    always_comb begin
        unique case (round_reg[5:4])
            2'd0: f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            2'd3: f_val = c_reg ^ (b_reg | ~d_reg);
            default: f_val = 32'h0;
        endcase
        sum_val = a_reg + f_val + round_const(round_reg) + mem_rdata_reg;
        b_new   = b_reg + rotl32(sum_val, rot_amount(round_reg));
    end

    // First padding word: gathered bytes, then the marker, then zeros.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (2'(j) < fill_reg[1:0]) begin
                pad_word[j*8 +: 8] = word_reg[j*8 +: 8];
            end else if (2'(j) == fill_reg[1:0]) begin
                pad_word[j*8 +: 8] = PAD_MARKER;
            end else begin
                pad_word[j*8 +: 8] = 8'h00;
            end
        end
    end

    // Sequencer: gather bytes, pad, compress and present the digest.
    always_comb begin
        state_next          = state_reg;
        chain_next          = chain_reg;
        a_next              = a_reg;
        b_next              = b_reg;
        c_next              = c_reg;
        d_next              = d_reg;
        round_next          = round_reg;
        fill_next           = fill_reg;
        bitlen_next         = bitlen_reg;
        word_next           = word_reg;
        pad_ptr_next        = pad_ptr_reg;
        pad_first_next      = pad_first_reg;
        len_pass_next       = len_pass_reg;
        pad_active_next     = pad_active_reg;
        finish_pending_next = finish_pending_reg;
        out_idx_next        = out_idx_reg;
        mem_we              = 1'b0;
        mem_waddr           = fill_reg[5:2];
        mem_wdata           = {s_data.data_byte, word_reg[23:0]};
        rd_addr             = 4'd0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    if (s_data.byte_present) begin
                        word_next[fill_reg[1:0]*8 +: 8] = s_data.data_byte;
                        mem_we      = (fill_reg[1:0] == 2'd3);
                        fill_next   = fill_reg + 6'd1;
                        bitlen_next = bitlen_reg + 64'd8;
                        if (fill_reg == 6'd63) begin
                            finish_pending_next = s_data.end_of_message;
                            state_next          = ST_CPRE;
                        end else if (s_data.end_of_message) begin
                            state_next = ST_FIN;
                        end
                    end else if (s_data.end_of_message) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                pad_ptr_next        = fill_reg[5:2];
                pad_first_next      = 1'b1;
                len_pass_next       = (fill_reg < LEN_START);
                pad_active_next     = 1'b1;
                finish_pending_next = 1'b0;
                state_next          = ST_PAD;
            end
            ST_PAD: begin
                mem_we    = 1'b1;
                mem_waddr = pad_ptr_reg;
                if (pad_first_reg) begin
                    mem_wdata = pad_word;
                end else if (len_pass_reg && pad_ptr_reg == 4'd14) begin
                    mem_wdata = bitlen_reg[31:0];
                end else if (len_pass_reg && pad_ptr_reg == 4'd15) begin
                    mem_wdata = bitlen_reg[63:32];
                end else begin
                    mem_wdata = 32'h0;
                end
                pad_first_next = 1'b0;
                pad_ptr_next   = pad_ptr_reg + 4'd1;
                if (pad_ptr_reg == 4'd15) begin
                    state_next = ST_CPRE;
                end
            end
            ST_CPRE: begin
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                round_next = 6'd0;
                rd_addr    = msg_index(6'd0);
                state_next = ST_CRND;
            end
            ST_CRND: begin
                a_next     = d_reg;
                b_next     = b_new;
                c_next     = b_reg;
                d_next     = c_reg;
                round_next = round_reg + 6'd1;
                rd_addr    = msg_index(round_reg + 6'd1);
                if (round_reg == 6'd63) begin
                    state_next = ST_CFIN;
                end
            end
            ST_CFIN: begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (pad_active_reg && len_pass_reg) begin
                    out_idx_next = 2'd0;
                    state_next   = ST_OUT;
                end else if (pad_active_reg) begin
                    // Length did not fit: a second block of zeros and length.
                    pad_ptr_next   = 4'd0;
                    pad_first_next = 1'b0;
                    len_pass_next  = 1'b1;
                    state_next     = ST_PAD;
                end else if (finish_pending_reg) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_beat) begin
                    out_idx_next = out_idx_reg + 2'd1;
                    if (out_idx_reg == 2'd3) begin
                        chain_next      = MD5_IV;
                        fill_next       = 6'd0;
                        bitlen_next     = 64'd0;
                        pad_active_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Block store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            blk_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= blk_mem[rd_addr];
    end

    // Working registers of the round datapath and the byte assembly word.
    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        word_reg <= word_next;
    end

    // Control and chaining state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            chain_reg          <= MD5_IV;
            round_reg          <= 6'd0;
            fill_reg           <= 6'd0;
            bitlen_reg         <= 64'd0;
            pad_ptr_reg        <= 4'd0;
            pad_first_reg      <= 1'b0;
            len_pass_reg       <= 1'b0;
            pad_active_reg     <= 1'b0;
            finish_pending_reg <= 1'b0;
            out_idx_reg        <= 2'd0;
        end else begin
            state_reg          <= state_next;
            chain_reg          <= chain_next;
            round_reg          <= round_next;
            fill_reg           <= fill_next;
            bitlen_reg         <= bitlen_next;
            pad_ptr_reg        <= pad_ptr_next;
            pad_first_reg      <= pad_first_next;
            len_pass_reg       <= len_pass_next;
            pad_active_reg     <= pad_active_next;
            finish_pending_reg <= finish_pending_next;
            out_idx_reg        <= out_idx_next;
        end
    end

`ifndef ASSERT_OFF
    // Input is never taken while a digest is being presented.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while digest is presented");

    // Digest words leave in order A, B, C, D without gaps.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_word) |=>
        (m_valid && m_data.word_index == 2'($past(m_data.word_index) + 2'd1)))
        else $error("digest word order broken");

    // After the final word the hash restarts from the initial values.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_word) |=>
        (chain_reg == MD5_IV && fill_reg == 6'd0 && bitlen_reg == 64'd0 && s_ready))
        else $error("hash state not restarted after digest");

    // The last round is always followed by the chaining update.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CRND && round_reg == 6'd63) |=> (state_reg == ST_CFIN))
        else $error("compression did not finish after round 63");
`endif

endmodule
